[sv/linear_probe_hash_table_top_assert.svh]
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_assert.svh
// Assertion macros for the hash table checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH

// same-cycle implication on clk, disabled during reset
`define LPHT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, disabled during reset
`define LPHT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, field widths and codes of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int LPHT_DEPTH = 1024;

	localparam int KEY_W    = 31;
	localparam int SIZE_W   = 11;
	localparam int SLOT_W   = 10;
	localparam int COUNT_W  = 11;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_TUSER_W = 3;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// modulo unit: dividend padded to a multiple of the radix
	localparam int MOD_DIVIDEND_W = 32;
	localparam int MOD_RADIX_BITS = 4;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_SEARCH = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_CHECK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic rd;
		logic check;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_done;
		logic probe_end;
		logic out_free;
	} stat_t;

endpackage

[sv/lpht_mod.sv]
// ----------------------------------------------------------------------------
// lpht_mod
// Iterative key modulo table size, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module lpht_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lpht_pkg::KEY_W-1:0]  dividend,
	input  logic [lpht_pkg::SIZE_W-1:0] divisor,
	output logic                       done,
	output logic [lpht_pkg::SIZE_W-1:0] remainder
);
	import lpht_pkg::*;

	localparam int STEPS = MOD_DIVIDEND_W / MOD_RADIX_BITS;
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [MOD_DIVIDEND_W-1:0] dvd_q;
	logic [SIZE_W-1:0]         rem_q;
	logic [SIZE_W-1:0]         div_q;
	logic [SIZE_W-1:0]         rem_next;
	logic [SIZE_W:0]           trial;

	always_comb begin
		rem_next = rem_q;
		trial    = '0;
		for (int i = 0; i < MOD_RADIX_BITS; i++) begin
			trial = {rem_next, dvd_q[MOD_DIVIDEND_W-1-i]};
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
			end
			rem_next = trial[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= MOD_DIVIDEND_W'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_q << MOD_RADIX_BITS;
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

[sv/lpht_dp.sv]
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: size register, key and valid memories, probe position, entry
// count and the output register.
// ----------------------------------------------------------------------------
module lpht_dp #(
	parameter int DEPTH = lpht_pkg::LPHT_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lpht_pkg::cmd_t               cmd,
	output lpht_pkg::stat_t              stat,
	input  logic                         cfg_valid,
	input  logic [lpht_pkg::SIZE_W-1:0]  cfg_data,
	input  lpht_pkg::req_t               in_type,
	input  logic [lpht_pkg::KEY_W-1:0]   in_key,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic                         out_found,
	output logic [lpht_pkg::SLOT_W-1:0]  out_slot,
	output lpht_pkg::status_t            out_status,
	output logic [lpht_pkg::COUNT_W-1:0] out_count
);
	import lpht_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [KEY_W-1:0]  key_mem [DEPTH];
	logic              vld_mem [DEPTH];

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n_act;
	logic [AW-1:0]     clr_q;
	logic [CW-1:0]     count_q;
	req_t              type_q;
	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] pos_q;
	logic [SIZE_W-1:0] probes_q;
	logic [KEY_W-1:0]  key_rd_q;
	logic              vld_rd_q;
	logic              res_found_q;
	logic [SLOT_W-1:0] res_slot_q;
	status_t           res_status_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic [SLOT_W-1:0] out_slot_q;
	status_t           out_status_q;
	logic [COUNT_W-1:0] out_count_q;

	logic              mod_done;
	logic [SIZE_W-1:0] mod_rem;
	logic              hit;
	logic              empty;
	logic              last;
	logic              ins_wr;
	logic              vld_we;
	logic [AW-1:0]     vld_waddr;
	logic [AW-1:0]     pos_addr;

	lpht_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.load),
		.dividend  (in_key),
		.divisor   (n_act),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// clamp size to 1..DEPTH
	always_comb begin
		if (size_q == '0) begin
			n_act = SIZE_W'(1);
		end else if (32'(size_q) > 32'(DEPTH)) begin
			n_act = SIZE_W'(DEPTH);
		end else begin
			n_act = size_q;
		end
	end

	assign pos_addr  = AW'(pos_q);
	assign empty     = !vld_rd_q;
	assign hit       = vld_rd_q && (key_rd_q == key_q);
	assign last      = (probes_q == n_act - SIZE_W'(1));
	assign ins_wr    = cmd.check && empty && (type_q == REQ_INSERT);
	assign vld_we    = cmd.clr_step || ins_wr;
	assign vld_waddr = cmd.clr_step ? clr_q : pos_addr;

	assign stat.clr_last  = (clr_q == AW'(DEPTH - 1));
	assign stat.mod_done  = mod_done;
	assign stat.probe_end = hit || empty || last;
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (ins_wr) begin
			key_mem[pos_addr] <= key_q;
		end
		if (cmd.rd) begin
			key_rd_q <= key_mem[pos_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_we) begin
			vld_mem[vld_waddr] <= !cmd.clr_step;
		end
		if (cmd.rd) begin
			vld_rd_q <= vld_mem[pos_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= SIZE_RESET;
			clr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				size_q <= cfg_data;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (ins_wr) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= in_type;
			key_q  <= in_key;
		end
		if (mod_done) begin
			pos_q    <= mod_rem;
			probes_q <= '0;
		end else if (cmd.check && !stat.probe_end) begin
			pos_q    <= (pos_q == n_act - SIZE_W'(1)) ? '0 : pos_q + SIZE_W'(1);
			probes_q <= probes_q + SIZE_W'(1);
		end
		if (cmd.check && stat.probe_end) begin
			if (empty) begin
				res_found_q  <= 1'b0;
				res_slot_q   <= (type_q == REQ_INSERT) ? SLOT_W'(pos_q) : '0;
				res_status_q <= (type_q == REQ_INSERT) ? STAT_OK : STAT_MISS;
			end else if (hit) begin
				res_found_q  <= 1'b1;
				res_slot_q   <= SLOT_W'(pos_q);
				res_status_q <= STAT_OK;
			end else begin
				res_found_q  <= 1'b0;
				res_slot_q   <= '0;
				res_status_q <= (type_q == REQ_INSERT) ? STAT_FULL : STAT_MISS;
			end
		end
		if (cmd.out_load) begin
			out_found_q  <= res_found_q;
			out_slot_q   <= res_slot_q;
			out_status_q <= res_status_q;
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_found  = out_found_q;
	assign out_slot   = out_slot_q;
	assign out_status = out_status_q;
	assign out_count  = out_count_q;

endmodule

[sv/lpht_ctrl.sv]
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: clearing pass, request intake, modulo wait, probe walk and
// result hand-off.
// ----------------------------------------------------------------------------
module lpht_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lpht_pkg::stat_t stat,
	output lpht_pkg::cmd_t  cmd
);
	import lpht_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_MOD;
				end
			end
			ST_MOD: begin
				if (stat.mod_done) begin
					state_next = ST_READ;
				end
			end
			ST_READ: begin
				state_next = ST_CHECK;
			end
			ST_CHECK: begin
				state_next = stat.probe_end ? ST_FINISH : ST_READ;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
			end
			ST_FINISH: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[sv/linear_probe_hash_table_top.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open addressing hash table with linear probing, insert and search requests.
// ----------------------------------------------------------------------------
// After reset the block clears all DEPTH entries of the valid memory (1024 by
// default) and holds s_axis_tready low until the sweep ends; table_size
// writes are taken at any time. One request is in flight at a time. A request
// passes through intake, the home slot (key modulo table size, four bits per
// cycle), a registered memory read and a compare for each probe, and the load
// of the output register. The walk ends on a hit, on an empty slot or after
// every slot of the clamped table size. A new request is taken while the
// previous result still waits on the master side.
module linear_probe_hash_table_top #(
	parameter int DEPTH = lpht_pkg::LPHT_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lpht_pkg::SIZE_W-1:0]      cfg_data,      // table_size
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [lpht_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // key[30:0], zero
	input  logic                             s_axis_tuser,  // req_type
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [lpht_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // slot, entry_count, zero
	output logic [lpht_pkg::OUT_TUSER_W-1:0] m_axis_tuser   // found, status[1:0]
);
	import lpht_pkg::*;

	localparam int PAD_W = OUT_TDATA_W - SLOT_W - COUNT_W;

	cmd_t               cmd;
	stat_t              stat;
	logic               out_found;
	logic [SLOT_W-1:0]  out_slot;
	status_t            out_status;
	logic [COUNT_W-1:0] out_count;

	lpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lpht_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_type    (req_t'(s_axis_tuser)),
		.in_key     (s_axis_tdata[KEY_W-1:0]),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_found  (out_found),
		.out_slot   (out_slot),
		.out_status (out_status),
		.out_count  (out_count)
	);

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {PAD_W'(0), out_count, out_slot};
	assign m_axis_tuser = {out_status, out_found};

endmodule

[sv/lpht_checker.sv]
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_top_assert.svh"

module lpht_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [lpht_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [lpht_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import lpht_pkg::*;

	`LPHT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	`LPHT_ASSERT_NXT(a_busy_after_transfer, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while one is in flight")

	`LPHT_ASSERT_IMP(a_found_ok, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[2:1] == STAT_OK, "found with failing status")

	`LPHT_ASSERT_IMP(a_fail_slot, m_axis_tvalid && (m_axis_tuser[2:1] != STAT_OK), (m_axis_tdata[SLOT_W-1:0] == '0) && !m_axis_tuser[0], "failed request with slot or found set")

endmodule

bind linear_probe_hash_table_top lpht_checker u_checker (.*);

[verif/linear_probe_hash_table_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_test
// Self-checking bench for the linear probing hash table.
// ----------------------------------------------------------------------------
// Keeps a shadow table of keys, valid bits, entry count and table size, and
// predicts found, slot, status and entry_count for every accepted request.
// Directed requests cover the key extremes, wrap-around, present keys,
// full walks and out-of-range sizes; random phases then sweep many table
// sizes with colliding, repeated and full-range keys under random idling on
// both streams and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top_test;
	import lpht_pkg::*;

	typedef struct packed {
		logic               found;
		logic [SLOT_W-1:0]  slot;
		status_t            status;
		logic [COUNT_W-1:0] entry_count;
	} table_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [SIZE_W-1:0]      cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;

	logic [KEY_W-1:0]   slot_key [LPHT_DEPTH];
	logic               slot_used [LPHT_DEPTH];
	logic [COUNT_W-1:0] occupancy;
	logic [SIZE_W-1:0]  table_size_q;

	table_result_t    pending_results [$];
	logic [KEY_W-1:0] recent_keys [$];
	int unsigned      error_count;
	int unsigned      hold_cycles;
	bit               idling;

	linear_probe_hash_table_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int unsigned effective_size();
		int unsigned n;
		n = 32'(table_size_q);
		if (n == 0)
			n = 1;
		if (n > LPHT_DEPTH)
			n = LPHT_DEPTH;
		return n;
	endfunction

	function automatic table_result_t probe_table(req_t req, logic [KEY_W-1:0] key);
		int unsigned   n;
		int unsigned   pos;
		int unsigned   probes;
		bit            done;
		table_result_t r;
		n = effective_size();
		pos = key % n;
		done = 1'b0;
		r.found = 1'b0;
		r.slot = '0;
		r.status = (req == REQ_SEARCH) ? STAT_MISS : STAT_FULL;
		for (probes = 0; probes < n && !done; probes++) begin
			if (!slot_used[SLOT_W'(pos)]) begin
				if (req == REQ_INSERT) begin
					slot_key[SLOT_W'(pos)] = key;
					slot_used[SLOT_W'(pos)] = 1'b1;
					occupancy = occupancy + 1'b1;
					r.slot = SLOT_W'(pos);
					r.status = STAT_OK;
				end
				done = 1'b1;
			end else if (slot_key[SLOT_W'(pos)] == key) begin
				r.found = 1'b1;
				r.slot = SLOT_W'(pos);
				r.status = STAT_OK;
				done = 1'b1;
			end else begin
				pos++;
				if (pos >= n)
					pos = 0;
			end
		end
		r.entry_count = occupancy;
		return r;
	endfunction

	// receiver: random idling, plus a counted hold-off on request
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			m_axis_tready <= idling ? ($urandom_range(99) >= 20) : 1'b1;
		end
	end

	always @(posedge clk) begin
		table_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no request outstanding");
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_axis_tuser[0] !== exp_r.found) begin
					$error("found: expected %0d, actual %0d", exp_r.found, m_axis_tuser[0]);
					error_count++;
				end
				if (m_axis_tdata[SLOT_W-1:0] !== exp_r.slot) begin
					$error("slot: expected %0d, actual %0d", exp_r.slot,
						m_axis_tdata[SLOT_W-1:0]);
					error_count++;
				end
				if (m_axis_tuser[2:1] !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status,
						m_axis_tuser[2:1]);
					error_count++;
				end
				if (m_axis_tdata[SLOT_W+COUNT_W-1:SLOT_W] !== exp_r.entry_count) begin
					$error("entry_count: expected %0d, actual %0d", exp_r.entry_count,
						m_axis_tdata[SLOT_W+COUNT_W-1:SLOT_W]);
					error_count++;
				end
			end
		end
	end

	task automatic send_request(req_t req, logic [KEY_W-1:0] key);
		if (idling && $urandom_range(99) < 20) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, key};
		s_axis_tuser <= req;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(probe_table(req, key));
		if (req == REQ_INSERT) begin
			recent_keys.push_back(key);
			if (recent_keys.size() > 48)
				void'(recent_keys.pop_front());
		end
	endtask

	task automatic send_random();
		int unsigned      n;
		int unsigned      pick;
		req_t             req;
		logic [KEY_W-1:0] key;
		n = effective_size();
		req = $urandom_range(1) ? REQ_SEARCH : REQ_INSERT;
		pick = $urandom_range(99);
		if (pick < 35 && recent_keys.size() != 0)
			key = recent_keys[$urandom_range(recent_keys.size() - 1)];
		else if (pick < 55)
			key = KEY_W'($urandom_range(3 * n));
		else if (pick < 75)
			key = KEY_W'(n * $urandom_range(1000) + $urandom_range(n - 1));
		else if (pick < 80)
			key = $urandom_range(1) ? '1 : '0;
		else
			key = KEY_W'($urandom());
		send_request(req, key);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(logic [SIZE_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		table_size_q = value;
	endtask

	task automatic test_default_size();
		send_request(REQ_INSERT, 31'd0);
		send_request(REQ_INSERT, 31'h7FFF_FFFF);
		send_request(REQ_INSERT, 31'd1024);
		send_request(REQ_INSERT, 31'd2047);
		send_request(REQ_SEARCH, 31'd2047);
		send_request(REQ_SEARCH, 31'd1024);
		send_request(REQ_INSERT, 31'd0);
		send_request(REQ_SEARCH, 31'd3);
		send_request(REQ_SEARCH, 31'h7FFF_FFFF);
	endtask

	task automatic test_size_extremes();
		write_size(11'd0);
		send_request(REQ_INSERT, 31'd5);
		send_request(REQ_SEARCH, 31'd0);
		send_request(REQ_SEARCH, 31'd9);
		send_request(REQ_INSERT, 31'd0);
		write_size(11'd1);
		send_request(REQ_SEARCH, 31'd1024);
		write_size(11'd2047);
		send_request(REQ_SEARCH, 31'd2047);
		send_request(REQ_INSERT, 31'd4);
		write_size(11'd2);
		send_request(REQ_INSERT, 31'd7);
		send_request(REQ_SEARCH, 31'd4);
	endtask

	task automatic test_output_hold_off();
		write_size(11'd64);
		hold_cycles = 400;
		repeat (30) send_random();
	endtask

	task automatic test_random_sizes();
		logic [SIZE_W-1:0] sizes [13];
		sizes = '{11'd1, 11'd2, 11'd5, 11'd13, 11'd31, 11'd64, 11'd100, 11'd200,
			11'd0, 11'd1023, 11'd1024, 11'd2047, 11'd1500};
		foreach (sizes[i]) begin
			write_size(sizes[i]);
			idling = (i != 6);
			repeat (42) send_random();
		end
		idling = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = SIZE_RESET;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_INSERT;
		m_axis_tready = 1'b0;
		hold_cycles = 0;
		idling = 1'b1;
		error_count = 0;
		occupancy = '0;
		table_size_q = SIZE_RESET;
		foreach (slot_used[i]) begin
			slot_used[i] = 1'b0;
			slot_key[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_size();
		test_size_extremes();
		test_output_hold_off();
		test_random_sizes();
		drain();
		repeat (64) @(posedge clk);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/lpht_pkg.sv
sv/lpht_mod.sv
sv/lpht_dp.sv
sv/lpht_ctrl.sv
sv/linear_probe_hash_table_top.sv
sv/lpht_checker.sv
verif/linear_probe_hash_table_top_test.sv
